>>> rtl/lcg_jump_ahead_core_macros.svh
// Assertion macros used by the block's top module.
`ifndef LCG_JUMP_AHEAD_CORE_MACROS_SVH
`define LCG_JUMP_AHEAD_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LJA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LJA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/lja_pkg.sv
// Package: shared types and codes of the jump-ahead block.
package lja_pkg;
  localparam int unsigned CFG_IDX_BITS = 2;
  typedef enum logic [1:0] {
    REG_MODULUS    = 2'd0,
    REG_MULTIPLIER = 2'd1,
    REG_INCREMENT  = 2'd2,
    REG_DIVISOR    = 2'd3
  } cfg_reg_t;
  // Opcodes of the modular engine.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_MOD = 2'd2
  } eng_op_t;
  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_BIT, ST_MM, ST_FIN, ST_OUT
  } ctl_state_t;
endpackage

>>> rtl/lja_channel_if.sv
// Valid/ready channel interface carrying a generic payload.
interface lja_channel_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lja_mod_engine.sv
// Bit-serial modular engine: shift-add multiply, add, and restoring remainder.
module lja_mod_engine #(
  parameter int unsigned VB = 62
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lja_pkg::eng_op_t op,
  input  logic [VB-1:0]    a,
  input  logic [VB-1:0]    b,
  input  logic [VB-1:0]    m,
  output logic             done,
  output logic [VB-1:0]    res
);
  import lja_pkg::*;
  localparam int unsigned CW = $clog2(VB + 1);

  logic            busy_r, busy_nxt;
  eng_op_t         op_r, op_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [VB:0]     acc_r, acc_nxt;
  logic [VB:0]     x_r, x_nxt;
  logic [VB-1:0]   y_r, y_nxt;
  logic [VB-1:0]   m_r, m_nxt;
  logic            done_r, done_nxt;
  logic [VB:0]     sum_w, dbl_w, rem_w, mext_w;

  assign mext_w = {1'b0, m_r};
  assign res    = acc_r[VB-1:0];
  assign done   = done_r;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    done_nxt = 1'b0;
    sum_w    = acc_r + x_r;
    dbl_w    = x_r + x_r;
    rem_w    = {acc_r[VB-1:0], y_r[VB-1]};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      m_nxt    = m;
      cnt_nxt  = '0;
      case (op)
        OP_MUL: begin
          acc_nxt = '0;
          x_nxt   = {1'b0, a};
          y_nxt   = b;
        end
        OP_ADD: begin
          acc_nxt = {1'b0, a};
          x_nxt   = {1'b0, b};
          y_nxt   = '0;
        end
        default: begin
          acc_nxt = '0;
          x_nxt   = '0;
          y_nxt   = a;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          // Both operands stay below m, so one subtract restores each sum.
          if (y_r[0])
            acc_nxt = (sum_w >= mext_w) ? sum_w - mext_w : sum_w;
          x_nxt = (dbl_w >= mext_w) ? dbl_w - mext_w : dbl_w;
          y_nxt = y_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(VB - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        OP_ADD: begin
          acc_nxt  = (sum_w >= mext_w) ? sum_w - mext_w : sum_w;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: begin
          // Shift in one dividend bit, MSB first, and subtract when it fits.
          acc_nxt = (rem_w >= mext_w) ? rem_w - mext_w : rem_w;
          y_nxt   = y_r << 1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(VB - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end
endmodule

>>> rtl/lcg_jump_ahead_core.sv
// LCG jump-ahead: x_n = a*x_(n-1)+c mod m after n steps, by 2x2 matrix powering.
// One request at a time. A request scans all STEP_BITS bits of the step count
// from the low end. Each bit costs a pass through the ST_BIT sequencing state, a
// squaring of the base matrix and, for a set bit, an accumulator product. The
// lower-left entry stays zero, so one matrix product is four serial modular
// multiplies (start, VALUE_BITS shift-add steps, done) plus one modular add.
// Reductions of seed, multiplier, increment and the final reduction by the result
// divisor are restoring remainders, and the closing a00*x0 + a01*c takes two
// more multiplies and an add. All of these run in turn on the single shared
// bit-serial modular engine. The result sits in an output register, and the
// next request is taken once it has been delivered. A zero modulus acts as 1;
// a zero result divisor leaves reduced_result equal to jumped_state.
module lcg_jump_ahead_core #(
  parameter int unsigned VALUE_BITS = 62,
  parameter int unsigned STEP_BITS  = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  lja_channel_if.sink   in_ch,
  lja_channel_if.source out_ch,
  lja_channel_if.sink   cfg_ch
);
  import lja_pkg::*;
  `include "lcg_jump_ahead_core_macros.svh"

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned SB = STEP_BITS;
  localparam int unsigned BW = (SB > 1) ? $clog2(SB) : 1;

  // Configuration registers.
  logic [VB-1:0] mod_r, mul_r, inc_r, div_r;
  // Matrix entries: acc = [[a00,a01],[0,a11]], base = [[b00,b01],[0,b11]].
  // The lower-left entries stay zero through every product.
  logic [VB-1:0] a00_r, a01_r, a11_r, b00_r, b01_r, b11_r;
  logic [VB-1:0] x0_r, c_r, t0_r, xn_r;
  logic [VB-1:0] n00_r, n01_r;
  logic [SB-1:0] n_r;
  logic [BW-1:0] bit_r;
  logic [3:0]    mstep_r;
  logic          sq_r;
  logic [2:0]    prep_r;
  logic [1:0]    fin_r;
  logic          eng_go_r;
  ctl_state_t    st_r, st_nxt;
  logic          ovalid_r;
  logic [VB-1:0] o_js_r, o_rr_r;
  logic [VB-1:0] m_eff;

  eng_op_t       e_op;
  logic [VB-1:0] e_a, e_b, e_res;
  logic          e_done;

  assign m_eff = (mod_r == '0) ? VB'(1) : mod_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= VB'(1);
      mul_r <= '0;
      inc_r <= '0;
      div_r <= VB'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.data[VB +: CFG_IDX_BITS]))
        REG_MODULUS:    mod_r <= cfg_ch.data[VB-1:0];
        REG_MULTIPLIER: mul_r <= cfg_ch.data[VB-1:0];
        REG_INCREMENT:  inc_r <= cfg_ch.data[VB-1:0];
        REG_DIVISOR:    div_r <= cfg_ch.data[VB-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = (st_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = {o_rr_r, o_js_r};

  // Engine operand select per sequencing step.
  always_comb begin
    e_op = OP_MUL;
    e_a  = '0;
    e_b  = '0;
    case (st_r)
      ST_PREP: begin
        e_op = OP_MOD;
        case (prep_r)
          3'd0:    e_a = x0_r;
          3'd1:    e_a = mul_r;
          default: e_a = inc_r;
        endcase
      end
      ST_MM: begin
        // Product P*Q with P = sq ? base : acc, Q = base; entries 00, 01, 11.
        e_op = OP_MUL;
        case (mstep_r)
          4'd0: begin e_a = sq_r ? b00_r : a00_r; e_b = b00_r; end
          4'd1: begin e_a = sq_r ? b00_r : a00_r; e_b = b01_r; end
          4'd2: begin e_a = sq_r ? b01_r : a01_r; e_b = b11_r; end
          4'd3: begin e_op = OP_ADD; e_a = t0_r; e_b = n01_r; end
          4'd4: begin e_a = sq_r ? b11_r : a11_r; e_b = b11_r; end
          default: ;
        endcase
      end
      ST_FIN: begin
        case (fin_r)
          2'd0: begin e_a = a00_r; e_b = x0_r; end
          2'd1: begin e_a = a01_r; e_b = c_r; end
          2'd2: begin e_op = OP_ADD; e_a = t0_r; e_b = n01_r; end
          default: begin e_op = OP_MOD; e_a = xn_r; end
        endcase
      end
      default: ;
    endcase
  end

  lja_mod_engine #(.VB(VB)) u_eng (
    .clk   (clk),
    .rst_n (rst_n),
    .start (eng_go_r),
    .op    (e_op),
    .a     (e_a),
    .b     (e_b),
    .m     ((st_r == ST_FIN && fin_r == 2'd3) ? div_r : m_eff),
    .done  (e_done),
    .res   (e_res)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_ch.valid && in_ch.ready) st_nxt = ST_PREP;
      ST_PREP: if (e_done && prep_r == 3'd2) st_nxt = ST_BIT;
      ST_BIT:  st_nxt = ST_MM;
      ST_MM: begin
        if (e_done && mstep_r == 4'd4 && sq_r)
          st_nxt = (bit_r == BW'(SB - 1)) ? ST_FIN : ST_BIT;
      end
      ST_FIN: begin
        if (e_done && fin_r == 2'd2 && div_r == '0) st_nxt = ST_OUT;
        if (e_done && fin_r == 2'd3) st_nxt = ST_OUT;
      end
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ovalid_r <= 1'b0;
      eng_go_r <= 1'b0;
      prep_r   <= '0;
      fin_r    <= '0;
      mstep_r  <= '0;
      bit_r    <= '0;
      sq_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      eng_go_r <= 1'b0;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            x0_r     <= in_ch.data[VB-1:0];
            n_r      <= in_ch.data[VB +: SB];
            prep_r   <= '0;
            eng_go_r <= 1'b1;
          end
        end
        ST_PREP: begin
          if (e_done) begin
            case (prep_r)
              3'd0:    x0_r <= e_res;
              3'd1:    b00_r <= e_res;
              default: c_r <= e_res;
            endcase
            if (prep_r != 3'd2) begin
              prep_r   <= prep_r + 3'd1;
              eng_go_r <= 1'b1;
            end else begin
              // 1 mod m: zero only when the effective modulus is one (modulus 0 or 1).
              a00_r <= (m_eff == VB'(1)) ? '0 : VB'(1);
              a11_r <= (m_eff == VB'(1)) ? '0 : VB'(1);
              a01_r <= '0;
              b01_r <= (m_eff == VB'(1)) ? '0 : VB'(1);
              b11_r <= (m_eff == VB'(1)) ? '0 : VB'(1);
              bit_r <= '0;
            end
          end
        end
        ST_BIT: begin
          // Multiply into the accumulator first when this step bit is set.
          sq_r     <= !n_r[0];
          mstep_r  <= '0;
          eng_go_r <= 1'b1;
        end
        ST_MM: begin
          if (e_done) begin
            case (mstep_r)
              4'd0: n00_r <= e_res;
              4'd1: t0_r  <= e_res;
              4'd2: n01_r <= e_res;
              4'd3: n01_r <= e_res;
              default: ;
            endcase
            if (mstep_r != 4'd4) begin
              mstep_r  <= mstep_r + 4'd1;
              eng_go_r <= 1'b1;
            end else begin
              if (sq_r) begin
                b00_r <= n00_r; b01_r <= n01_r; b11_r <= e_res;
                n_r   <= n_r >> 1;
                bit_r <= bit_r + 1'b1;
                if (bit_r == BW'(SB - 1)) begin
                  fin_r    <= '0;
                  eng_go_r <= 1'b1;
                end
              end else begin
                a00_r <= n00_r; a01_r <= n01_r; a11_r <= e_res;
                sq_r     <= 1'b1;
                mstep_r  <= '0;
                eng_go_r <= 1'b1;
              end
            end
          end
        end
        ST_FIN: begin
          if (e_done) begin
            case (fin_r)
              2'd0: t0_r  <= e_res;
              2'd1: n01_r <= e_res;
              2'd2: xn_r  <= e_res;
              default: ;
            endcase
            if (fin_r == 2'd2) begin
              o_js_r <= e_res;
              o_rr_r <= e_res;
              if (div_r != '0) begin
                fin_r    <= 2'd3;
                eng_go_r <= 1'b1;
              end
            end else if (fin_r == 2'd3) begin
              o_rr_r <= e_res;
            end else begin
              fin_r    <= fin_r + 2'd1;
              eng_go_r <= 1'b1;
            end
          end
        end
        ST_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  `LJA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !ovalid_r && st_r == ST_IDLE, "input taken while busy")
  `LJA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "result dropped while stalled")
  `LJA_ASSERT_IMP(a_state_range, clk, rst_n, ovalid_r, o_js_r < m_eff, "jumped state not reduced")
endmodule
